[design/sdrdf_pkg.sv]
package sdrdf_pkg;

    // Frame geometry
    localparam int FRAME_BYTES   = 512;
    localparam int MAX_RECEIVERS = 8;
    localparam int HDR_BYTES     = 8;
    localparam int GRP_MAX       = 63;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 24;
    localparam int SECOND_W = 16;
    localparam int RX_IDX_W = 3;
    localparam int GRP_W    = 6;
    localparam int RX_CNT_W = 4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC     = 1'd1;

    localparam logic [RX_CNT_W-1:0] RX_COUNT_RST = 4'd1;
    localparam logic [BYTE_W-1:0]   SYNC_RST     = 8'd127;

    // Queue between parser and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Saturate a raw group count into [1, GRP_MAX]
    function automatic logic [GRP_W-1:0] grp_sat(input int raw);
        logic [GRP_W-1:0] res;
        if (raw > GRP_MAX) begin
            res = GRP_W'(GRP_MAX);
        end else if (raw < 1) begin
            res = GRP_W'(1);
        end else begin
            res = GRP_W'(raw);
        end
        return res;
    endfunction

    // Groups per frame, indexed by (receivers - 1)
    localparam logic [GRP_W-1:0] GPF_TAB [MAX_RECEIVERS] = '{
        grp_sat((FRAME_BYTES - HDR_BYTES) / (6 * 1 + 2)),
        grp_sat((FRAME_BYTES - HDR_BYTES) / (6 * 2 + 2)),
        grp_sat((FRAME_BYTES - HDR_BYTES) / (6 * 3 + 2)),
        grp_sat((FRAME_BYTES - HDR_BYTES) / (6 * 4 + 2)),
        grp_sat((FRAME_BYTES - HDR_BYTES) / (6 * 5 + 2)),
        grp_sat((FRAME_BYTES - HDR_BYTES) / (6 * 6 + 2)),
        grp_sat((FRAME_BYTES - HDR_BYTES) / (6 * 7 + 2)),
        grp_sat((FRAME_BYTES - HDR_BYTES) / (6 * 8 + 2))
    };

    // Parser phases
    typedef enum logic [15:0] {
        PH_SYNC0 = 16'h0001,
        PH_SYNC1 = 16'h0002,
        PH_SYNC2 = 16'h0004,
        PH_CTRL0 = 16'h0008,
        PH_CTRL1 = 16'h0010,
        PH_CTRL2 = 16'h0020,
        PH_CTRL3 = 16'h0040,
        PH_CTRL4 = 16'h0080,
        PH_QHI   = 16'h0100,
        PH_QMID  = 16'h0200,
        PH_QLO   = 16'h0400,
        PH_IHI   = 16'h0800,
        PH_IMID  = 16'h1000,
        PH_ILO   = 16'h2000,
        PH_MICHI = 16'h4000,
        PH_MICLO = 16'h8000
    } t_phase;

    // One completed I/Q pair
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] i_sample;
        logic signed [SAMPLE_W-1:0] q_sample;
        logic [RX_IDX_W-1:0]        receiver_index;
        logic [GRP_W-1:0]           sample_index;
        logic                       last_in_frame;
    } t_pair;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[design/sdrdf_byte_if.sv]
interface sdrdf_byte_if;
    logic                          valid;
    logic                          ready;
    logic [sdrdf_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

[design/sdrdf_pair_if.sv]
interface sdrdf_pair_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sdrdf_pkg::SAMPLE_W-1:0] i_sample;
    logic signed [sdrdf_pkg::SAMPLE_W-1:0] q_sample;
    logic [sdrdf_pkg::RX_IDX_W-1:0]       receiver_index;
    logic [sdrdf_pkg::GRP_W-1:0]          sample_index;
    logic                                 last_in_frame;

    modport source (output valid, output i_sample, output q_sample, output receiver_index,
                    output sample_index, output last_in_frame, input ready);
    modport sink   (input valid, input i_sample, input q_sample, input receiver_index,
                    input sample_index, input last_in_frame, output ready);
endinterface

[design/sdr_rx_frame_iq_deframer_core.sv]
// Throughput: one byte word per cycle, sustained, as long as the output side keeps up.
// A pair word is written into the 4-entry queue when its last I byte is taken, and is
// then moved to the output register when that register is empty or being taken.
// The input stalls only when the 4-entry queue between parser and output stage is full.
// Reset (i_rst_n low, synchronous) returns the parser to sync search, empties the queue,
// drops the output word and restores receiver_count = 1 and sync_value = 127.
module sdr_rx_frame_iq_deframer_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [sdrdf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sdrdf_pkg::BYTE_W-1:0]     i_cfg_wdata,
    sdrdf_byte_if.sink                       i_byte,
    sdrdf_pair_if.source                     o_pair
);

    logic                 push;
    logic                 pop;
    sdrdf_pkg::t_pair     push_pair;
    sdrdf_pkg::t_pair     head;
    sdrdf_pkg::t_q_status q_status;

    // Byte parser
    sdrdf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte      (i_byte),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_pair      (push_pair)
    );

    // Pair queue
    sdrdf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pair   (push_pair),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // Output register
    sdrdf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_head     (head),
        .o_pop      (pop),
        .o_pair     (o_pair)
    );

endmodule

[design/sdrdf_front.sv]
module sdrdf_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [sdrdf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sdrdf_pkg::BYTE_W-1:0]       i_cfg_wdata,
    sdrdf_byte_if.sink                         i_byte,
    input  sdrdf_pkg::t_q_status               i_q_status,
    output logic                               o_push,
    output sdrdf_pkg::t_pair                   o_pair
);

    // Config registers
    logic [sdrdf_pkg::RX_CNT_W-1:0] r_rx_count;
    logic [sdrdf_pkg::BYTE_W-1:0]   r_sync;

    // Parser state
    sdrdf_pkg::t_phase              r_phase, n_phase;
    logic [sdrdf_pkg::SAMPLE_W-1:0] r_first, n_first;
    logic [sdrdf_pkg::SECOND_W-1:0] r_second, n_second;
    logic [sdrdf_pkg::RX_IDX_W-1:0] r_rx, n_rx;
    logic [sdrdf_pkg::GRP_W-1:0]    r_grp, n_grp;
    logic [sdrdf_pkg::GRP_W-1:0]    r_gpf, n_gpf;

    logic                           accept;
    logic [sdrdf_pkg::BYTE_W-1:0]   b;
    logic [sdrdf_pkg::RX_CNT_W-1:0] n_eff;
    logic [sdrdf_pkg::RX_CNT_W-1:0] next_rx;
    logic [sdrdf_pkg::GRP_W:0]      next_grp;
    logic                           group_done;
    logic                           frame_end;

    assign i_byte.ready = !i_q_status.full;
    assign accept       = i_byte.valid && i_byte.ready;
    assign b            = i_byte.data_byte;

    // Config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_count <= sdrdf_pkg::RX_COUNT_RST;
            r_sync     <= sdrdf_pkg::SYNC_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                sdrdf_pkg::CFG_RX_COUNT: r_rx_count <= i_cfg_wdata[sdrdf_pkg::RX_CNT_W-1:0];
                sdrdf_pkg::CFG_SYNC:     r_sync     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective receiver count, clamped to [1, MAX_RECEIVERS]
    always_comb begin
        if (r_rx_count == '0) begin
            n_eff = sdrdf_pkg::RX_CNT_W'(1);
        end else if (r_rx_count > sdrdf_pkg::RX_CNT_W'(sdrdf_pkg::MAX_RECEIVERS)) begin
            n_eff = sdrdf_pkg::RX_CNT_W'(sdrdf_pkg::MAX_RECEIVERS);
        end else begin
            n_eff = r_rx_count;
        end
    end

    assign next_rx    = {1'b0, r_rx} + sdrdf_pkg::RX_CNT_W'(1);
    assign group_done = next_rx >= n_eff;
    assign next_grp   = {1'b0, r_grp} + (sdrdf_pkg::GRP_W + 1)'(1);
    assign frame_end  = next_grp >= {1'b0, r_gpf};

    // Phase sequencer
    always_comb begin
        n_phase  = r_phase;
        n_first  = r_first;
        n_second = r_second;
        n_rx     = r_rx;
        n_grp    = r_grp;
        n_gpf    = r_gpf;
        case (r_phase)
            sdrdf_pkg::PH_SYNC0: begin
                if (b == r_sync) n_phase = sdrdf_pkg::PH_SYNC1;
            end
            sdrdf_pkg::PH_SYNC1: begin
                if (b == r_sync) n_phase = sdrdf_pkg::PH_SYNC2;
            end
            sdrdf_pkg::PH_SYNC2: begin
                if (b == r_sync) n_phase = sdrdf_pkg::PH_CTRL0;
            end
            sdrdf_pkg::PH_CTRL0: n_phase = sdrdf_pkg::PH_CTRL1;
            sdrdf_pkg::PH_CTRL1: n_phase = sdrdf_pkg::PH_CTRL2;
            sdrdf_pkg::PH_CTRL2: n_phase = sdrdf_pkg::PH_CTRL3;
            sdrdf_pkg::PH_CTRL3: n_phase = sdrdf_pkg::PH_CTRL4;
            sdrdf_pkg::PH_CTRL4: begin
                n_gpf   = sdrdf_pkg::GPF_TAB[sdrdf_pkg::RX_IDX_W'(n_eff - 1'b1)];
                n_rx    = '0;
                n_grp   = '0;
                n_phase = sdrdf_pkg::PH_QHI;
            end
            sdrdf_pkg::PH_QHI: begin
                n_first = {b, 16'h0000};
                n_phase = sdrdf_pkg::PH_QMID;
            end
            sdrdf_pkg::PH_QMID: begin
                n_first = {r_first[23:16], b, r_first[7:0]};
                n_phase = sdrdf_pkg::PH_QLO;
            end
            sdrdf_pkg::PH_QLO: begin
                n_first = {r_first[23:8], b};
                n_phase = sdrdf_pkg::PH_IHI;
            end
            sdrdf_pkg::PH_IHI: begin
                n_second = {b, 8'h00};
                n_phase  = sdrdf_pkg::PH_IMID;
            end
            sdrdf_pkg::PH_IMID: begin
                n_second = {r_second[15:8], b};
                n_phase  = sdrdf_pkg::PH_ILO;
            end
            sdrdf_pkg::PH_ILO: begin
                n_rx    = next_rx[sdrdf_pkg::RX_IDX_W-1:0];
                n_phase = group_done ? sdrdf_pkg::PH_MICHI : sdrdf_pkg::PH_QHI;
            end
            sdrdf_pkg::PH_MICHI: n_phase = sdrdf_pkg::PH_MICLO;
            sdrdf_pkg::PH_MICLO: begin
                if (frame_end) begin
                    n_phase = sdrdf_pkg::PH_SYNC0;
                end else begin
                    n_grp   = next_grp[sdrdf_pkg::GRP_W-1:0];
                    n_rx    = '0;
                    n_phase = sdrdf_pkg::PH_QHI;
                end
            end
            default: n_phase = sdrdf_pkg::PH_SYNC0;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sdrdf_pkg::PH_SYNC0;
            r_rx    <= '0;
            r_grp   <= '0;
            r_gpf   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_rx    <= n_rx;
            r_grp   <= n_grp;
            r_gpf   <= n_gpf;
        end
    end

    // Sample accumulators
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    // Completed pair goes to the queue on the last I byte
    assign o_push                = accept && (r_phase == sdrdf_pkg::PH_ILO);
    assign o_pair.i_sample       = {r_second, b};
    assign o_pair.q_sample       = r_first;
    assign o_pair.receiver_index = r_rx;
    assign o_pair.sample_index   = r_grp;
    assign o_pair.last_in_frame  = group_done && frame_end;

endmodule

[design/sdrdf_queue.sv]
module sdrdf_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  sdrdf_pkg::t_pair      i_pair,
    input  logic                  i_pop,
    output sdrdf_pkg::t_pair      o_head,
    output sdrdf_pkg::t_q_status  o_status
);

    sdrdf_pkg::t_pair                r_store [sdrdf_pkg::QUEUE_DEPTH];
    logic [sdrdf_pkg::QPTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [sdrdf_pkg::QCNT_W-1:0]    r_count, n_count;

    assign o_status.full  = r_count == sdrdf_pkg::QCNT_W'(sdrdf_pkg::QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;
    assign o_head         = r_store[r_rd_ptr];

    // Occupancy
    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_store[r_wr_ptr] <= i_pair;
    end

endmodule

[design/sdrdf_back.sv]
module sdrdf_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sdrdf_pkg::t_q_status  i_q_status,
    input  sdrdf_pkg::t_pair      i_head,
    output logic                  o_pop,
    sdrdf_pair_if.source          o_pair
);

    logic             r_valid;
    sdrdf_pkg::t_pair r_word;

    // Refill the output register from the queue whenever it is empty or being taken and the queue holds a word
    assign o_pop = !i_q_status.empty && (!r_valid || o_pair.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_pair.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_word <= i_head;
    end

    assign o_pair.valid          = r_valid;
    assign o_pair.i_sample       = r_word.i_sample;
    assign o_pair.q_sample       = r_word.q_sample;
    assign o_pair.receiver_index = r_word.receiver_index;
    assign o_pair.sample_index   = r_word.sample_index;
    assign o_pair.last_in_frame  = r_word.last_in_frame;

endmodule

[design/sdrdf_checker.sv]
module sdrdf_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [sdrdf_pkg::SAMPLE_W-1:0] i_i_sample,
    input logic signed [sdrdf_pkg::SAMPLE_W-1:0] i_q_sample
);

    // Fewest bytes before a first pair: three sync, five control, six sample
    localparam logic [3:0] MIN_BYTES = 4'd14;

    logic [3:0] r_in_cnt, n_in_cnt;

    always_comb begin
        n_in_cnt = r_in_cnt;
        if (i_in_valid && i_in_ready && r_in_cnt != 4'hF) n_in_cnt = r_in_cnt + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt <= '0;
        end else begin
            r_in_cnt <= n_in_cnt;
        end
    end

    // Held word stays valid
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output word dropped while stalled");

    // Held word keeps its samples
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_i_sample) && $stable(i_q_sample)))
        else $error("output samples changed while stalled");

    // Reset empties the output
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // No pair before a full header and the six bytes of one pair
    a_no_early_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_in_cnt >= MIN_BYTES))
        else $error("pair word before enough bytes were taken");

endmodule

bind sdr_rx_frame_iq_deframer_core sdrdf_checker u_sdrdf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_byte.valid),
    .i_in_ready  (i_byte.ready),
    .i_out_valid (o_pair.valid),
    .i_out_ready (o_pair.ready),
    .i_i_sample  (o_pair.i_sample),
    .i_q_sample  (o_pair.q_sample)
);
